// ----- src/mlt_pkg.sv -----
// Shared constants, types and a helper function of the address table.
package mlt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int PORT_COUNT    = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ADDR_W        = 48;
    localparam int PORT_W        = 4;
    localparam int AGE_W         = 8;
    localparam int COUNT_W       = 7;
    localparam int KIND_W        = 2;

    localparam logic [AGE_W-1:0]   AGE_MAX       = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
    localparam logic [AGE_W-1:0]   TIMEOUT_RESET = 8'd30;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic item_load;
        logic search;
        logic resolve;
        logic tick_clear;
        logic tick_read;
        logic tick_write;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  tick_last;
    } stat_t;

    // Returns the index of the lowest set bit of the vector.
    function automatic logic [IDX_W-1:0] first_set(input logic [TABLE_ENTRIES-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (vec[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- src/mac_learning_table_with_aging.sv -----
// Top level of the switch address table with learning and aging.
//
//  Channel   Signals                                   Direction
//  input     in_valid, in_ready, kind, mac_address,    item in
//            port_in
//  output    out_valid, out_ready, hit, port_out,      item out
//            status, removed_count
//  config    cfg_wr_en, cfg_wr_data (age_timeout)      write only
//
// A lookup or insert runs through compare, resolve with memory access and result load;
// the next item is accepted only after the result load, back in the idle state.
// A tick sweeps all 64 entries, a read and a write step per entry for the single age
// memory port, between dispatch and result load.
// Reset clears all valid bits at once, so no clearing pass follows it.
// A result waiting on the output stalls only the following item, in its last state.
module mac_learning_table_with_aging (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mlt_pkg::KIND_W-1:0]    kind,
    input  logic [mlt_pkg::ADDR_W-1:0]    mac_address,
    input  logic [mlt_pkg::PORT_W-1:0]    port_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic [mlt_pkg::PORT_W-1:0]    port_out,
    output logic                          status,
    output logic [mlt_pkg::COUNT_W-1:0]   removed_count,
    input  logic                          cfg_wr_en,
    input  logic [mlt_pkg::AGE_W-1:0]     cfg_wr_data
);

    mlt_pkg::cmd_t  cmd;
    mlt_pkg::stat_t stat;

    mlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mlt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .kind          (kind),
        .mac_address   (mac_address),
        .port_in       (port_in),
        .hit           (hit),
        .port_out      (port_out),
        .status        (status),
        .removed_count (removed_count)
    );

endmodule

// ----- src/mlt_ctrl.sv -----
// Controller state machine that sequences lookups, inserts and aging sweeps.
module mlt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  mlt_pkg::stat_t stat,
    output mlt_pkg::cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SEARCH  = 6'b000010,
        ST_RESOLVE = 6'b000100,
        ST_TICK_RD = 6'b001000,
        ST_TICK_WR = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (stat.kind == mlt_pkg::KIND_TICK)
                begin
                    cmd.tick_clear = 1'b1;
                    state_next     = ST_TICK_RD;
                end
                else
                begin
                    cmd.search = 1'b1;
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = ST_DONE;
            end
            ST_TICK_RD:
            begin
                cmd.tick_read = 1'b1;
                state_next    = ST_TICK_WR;
            end
            ST_TICK_WR:
            begin
                cmd.tick_write = 1'b1;
                state_next     = stat.tick_last ? ST_DONE : ST_TICK_RD;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/mlt_datapath.sv -----
// Datapath holding the address table, port and age memories and result registers.
module mlt_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mlt_pkg::cmd_t                 cmd,
    output mlt_pkg::stat_t                stat,
    input  logic                          cfg_wr_en,
    input  logic [mlt_pkg::AGE_W-1:0]     cfg_wr_data,
    input  logic [mlt_pkg::KIND_W-1:0]    kind,
    input  logic [mlt_pkg::ADDR_W-1:0]    mac_address,
    input  logic [mlt_pkg::PORT_W-1:0]    port_in,
    output logic                          hit,
    output logic [mlt_pkg::PORT_W-1:0]    port_out,
    output logic                          status,
    output logic [mlt_pkg::COUNT_W-1:0]   removed_count
);

    localparam int N = mlt_pkg::TABLE_ENTRIES;

    logic [mlt_pkg::AGE_W-1:0]   timeout_reg;
    mlt_pkg::kind_t              kind_reg;
    logic [mlt_pkg::ADDR_W-1:0]  key_reg;
    logic [mlt_pkg::PORT_W-1:0]  item_port_reg;

    logic [N-1:0]                valid_reg;
    logic [N-1:0]                valid_next;
    logic [mlt_pkg::ADDR_W-1:0]  addr_reg [N];
    logic [mlt_pkg::PORT_W-1:0]  port_mem [N];
    logic [mlt_pkg::AGE_W-1:0]   age_mem  [N];

    logic [N-1:0]                match_reg;
    logic [N-1:0]                match_next;
    logic [mlt_pkg::PORT_W-1:0]  port_rdata_reg;
    logic [mlt_pkg::AGE_W-1:0]   age_rdata_reg;
    logic [mlt_pkg::IDX_W-1:0]   tick_idx_reg;

    logic                        hit_reg;
    logic                        hit_next;
    logic                        status_reg;
    logic                        status_next;
    logic [mlt_pkg::COUNT_W-1:0] removed_reg;
    logic [mlt_pkg::COUNT_W-1:0] removed_next;

    logic                        hit_out_reg;
    logic [mlt_pkg::PORT_W-1:0]  port_out_reg;
    logic                        status_out_reg;
    logic [mlt_pkg::COUNT_W-1:0] removed_out_reg;

    logic                        match_any;
    logic                        free_any;
    logic [mlt_pkg::IDX_W-1:0]   match_idx;
    logic [mlt_pkg::IDX_W-1:0]   free_idx;
    logic                        port_ok;
    logic                        ins_we;
    logic [mlt_pkg::IDX_W-1:0]   ins_idx;
    logic                        age_we;
    logic [mlt_pkg::IDX_W-1:0]   age_waddr;
    logic [mlt_pkg::AGE_W-1:0]   age_wdata;
    logic [mlt_pkg::AGE_W-1:0]   age_inc;
    logic                        tick_valid;
    logic                        tick_remove;

    assign stat.kind      = kind_reg;
    assign stat.tick_last = (tick_idx_reg == mlt_pkg::IDX_W'(N - 1));

    assign hit           = hit_out_reg;
    assign port_out      = port_out_reg;
    assign status        = status_out_reg;
    assign removed_count = removed_out_reg;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            match_next[i] = valid_reg[i] && (addr_reg[i] == key_reg);
        end
    end

    assign match_any = |match_reg;
    assign free_any  = ~&valid_reg;
    assign match_idx = mlt_pkg::first_set(match_reg);
    assign free_idx  = mlt_pkg::first_set(~valid_reg);
    assign port_ok   = (int'(item_port_reg) < mlt_pkg::PORT_COUNT);

    assign age_inc     = (age_rdata_reg == mlt_pkg::AGE_MAX) ? age_rdata_reg
                                                             : age_rdata_reg + 8'd1;
    assign tick_valid  = valid_reg[tick_idx_reg];
    assign tick_remove = tick_valid && (age_inc >= timeout_reg);

    always_comb
    begin
        ins_we       = 1'b0;
        ins_idx      = match_any ? match_idx : free_idx;
        age_we       = 1'b0;
        age_waddr    = ins_idx;
        age_wdata    = '0;
        valid_next   = valid_reg;
        hit_next     = hit_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        if (cmd.item_load)
        begin
            hit_next     = 1'b0;
            status_next  = 1'b0;
            removed_next = '0;
        end
        if (cmd.resolve)
        begin
            case (kind_reg)
                mlt_pkg::KIND_LOOKUP:
                begin
                    if (match_any)
                    begin
                        hit_next  = 1'b1;
                        age_we    = 1'b1;
                        age_waddr = match_idx;
                    end
                end
                mlt_pkg::KIND_INSERT:
                begin
                    if (port_ok)
                    begin
                        if (match_any || free_any)
                        begin
                            ins_we              = 1'b1;
                            age_we              = 1'b1;
                            valid_next[ins_idx] = 1'b1;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.tick_write && tick_valid)
        begin
            age_we    = 1'b1;
            age_waddr = tick_idx_reg;
            age_wdata = age_inc;
            if (tick_remove)
            begin
                valid_next[tick_idx_reg] = 1'b0;
                if (removed_reg != mlt_pkg::COUNT_MAX)
                begin
                    removed_next = removed_reg + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= mlt_pkg::TIMEOUT_RESET;
            valid_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            kind_reg      <= mlt_pkg::kind_t'(kind);
            key_reg       <= mac_address;
            item_port_reg <= port_in;
        end
        if (cmd.search)
        begin
            match_reg <= match_next;
        end
        if (cmd.resolve)
        begin
            port_rdata_reg <= port_mem[match_idx];
        end
        if (ins_we)
        begin
            addr_reg[ins_idx] <= key_reg;
            port_mem[ins_idx] <= item_port_reg;
        end
        if (age_we)
        begin
            age_mem[age_waddr] <= age_wdata;
        end
        if (cmd.tick_read)
        begin
            age_rdata_reg <= age_mem[tick_idx_reg];
        end
        if (cmd.tick_clear)
        begin
            tick_idx_reg <= '0;
        end
        else if (cmd.tick_write)
        begin
            tick_idx_reg <= tick_idx_reg + mlt_pkg::IDX_W'(1);
        end
        hit_reg     <= hit_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        if (cmd.out_load)
        begin
            hit_out_reg     <= hit_reg;
            port_out_reg    <= hit_reg ? port_rdata_reg : '0;
            status_out_reg  <= status_reg;
            removed_out_reg <= removed_reg;
        end
    end

endmodule

// ----- src/mlt_checker.sv -----
// Port-level checker for the address table, bound to the top level.
module mlt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          hit,
    input logic [mlt_pkg::PORT_W-1:0]    port_out,
    input logic                          status,
    input logic [mlt_pkg::COUNT_W-1:0]   removed_count
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while one is in progress");

    // A hit comes only from a lookup, which never reports full or removals.
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> (status == 1'b0) && (removed_count == '0))
        else $error("hit result carries insert or tick fields");

    // A miss carries port zero.
    a_miss_port: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (port_out == '0))
        else $error("nonzero port on a result without a hit");

endmodule

bind mac_learning_table_with_aging mlt_checker u_mlt_checker (.*);
